/* hw/rtl/lsd_pkg.sv */
// Shared types and constants for the LSB steganography stream decoder.
// No dependencies; the decode core, top level and checker import this package.
`default_nettype none

package lsd_pkg;

  // Decoder geometry.
  localparam int EXT_CHARS    = 4;
  localparam int LENGTH_BYTES = 8;
  localparam int LEN_IDX_W    = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

  // Register reset values.
  localparam logic [15:0] HEADER_SKIP_RESET  = 16'd54;
  localparam logic [7:0]  MAGIC_FIRST_RESET  = 8'd35;
  localparam logic [7:0]  MAGIC_SECOND_RESET = 8'd42;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEADER_SKIP  = 2'd0;
  localparam logic [1:0] REG_MAGIC_FIRST  = 2'd1;
  localparam logic [1:0] REG_MAGIC_SECOND = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_EXT    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_EARLY_END = 2'd2;
  localparam logic [1:0] ST_COMPLETE  = 2'd3;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       first_of_file;
    logic       last_of_file;
  } lsd_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic [1:0] status;
    logic       final_res;
  } lsd_result_t;

  typedef struct packed {
    logic [15:0] header_skip;
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
  } lsd_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/lsd_image_if.sv */
// Stream interface carrying image bytes into the decoder.
// Depends on nothing but plain logic types.
`default_nettype none

interface lsd_image_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       first_of_file;
  logic       last_of_file;

  modport source (output valid, output image_byte, output first_of_file,
                  output last_of_file, input ready);
  modport sink   (input valid, input image_byte, input first_of_file,
                  input last_of_file, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lsd_hidden_if.sv */
// Stream interface carrying decoded hidden bytes and status out of the decoder.
// Depends on nothing but plain logic types.
`default_nettype none

interface lsd_hidden_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [1:0] status;
  logic       final_res;

  modport source (output valid, output out_byte, output out_kind,
                  output status, output final_res, input ready);
  modport sink   (input valid, input out_byte, input out_kind,
                  input status, input final_res, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lsd_decode_core.sv */
// Decode state and single-pass next-state logic for one image byte.
// Depends on lsd_pkg for item, result and configuration types.
`default_nettype none

module lsd_decode_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire lsd_pkg::lsd_item_t  item,
  input  wire lsd_pkg::lsd_cfg_t   cfg,
  output logic                     have,
  output lsd_pkg::lsd_result_t     result
);
  import lsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_MAGIC, PH_EXT, PH_LEN, PH_DATA, PH_IDLE
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] header_count, header_count_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [3:0]  field_index, field_index_next;
  logic [7:0]  shift_bits, shift_bits_next;
  logic [7:0]  first_magic_seen;
  logic [7:0]  len_bytes [LENGTH_BYTES];
  logic [63:0] remaining, remaining_next;

  phase_t      ph;
  logic [15:0] hc;
  logic [2:0]  bc;
  logic [3:0]  fi;
  logic [3:0]  fi_inc;
  logic [7:0]  hbyte;
  logic        byte_done;
  logic        magic_wr;
  logic        len_wr;
  logic [8*LENGTH_BYTES-1:0] len_raw;
  logic [63:0] len_full;

  // The length as it stands once the current byte is placed in the top slot.
  always_comb begin
    for (int j = 0; j < LENGTH_BYTES; j++) begin
      len_raw[8*j +: 8] = (j == LENGTH_BYTES - 1) ? hbyte : len_bytes[j];
    end
    len_full = 64'($signed(len_raw));
  end

  always_comb begin
    // A first-of-file mark restarts the file before this byte is used.
    ph = item.first_of_file ? PH_HEADER : phase;
    hc = item.first_of_file ? 16'd0 : header_count;
    bc = item.first_of_file ? 3'd0 : bit_count;
    fi = item.first_of_file ? 4'd0 : field_index;
    fi_inc = fi + 4'd1;
    hbyte = {shift_bits[6:0], item.image_byte[0]};

    phase_next        = ph;
    header_count_next = hc;
    bit_count_next    = bc;
    field_index_next  = fi;
    shift_bits_next   = shift_bits;
    remaining_next    = remaining;
    byte_done         = 1'b0;
    magic_wr          = 1'b0;
    len_wr            = 1'b0;
    have              = 1'b0;
    result            = '{out_byte: 8'd0, out_kind: KIND_STATUS, status: ST_OK,
                          final_res: 1'b0};

    if (ph != PH_IDLE) begin
      if (ph == PH_HEADER && hc < cfg.header_skip) begin
        header_count_next = hc + 16'd1;
      end else begin
        phase_next      = (ph == PH_HEADER) ? PH_MAGIC : ph;
        shift_bits_next = hbyte;
        bit_count_next  = bc + 3'd1;
        byte_done       = (bc == 3'd7);
      end
    end

    if (byte_done) begin
      case (phase_next)
        PH_MAGIC: begin
          if (fi == 4'd0) begin
            magic_wr         = 1'b1;
            field_index_next = 4'd1;
          end else begin
            field_index_next = 4'd0;
            if (first_magic_seen != cfg.magic_first || hbyte != cfg.magic_second) begin
              have       = 1'b1;
              result     = '{out_byte: 8'd0, out_kind: KIND_STATUS,
                             status: ST_BAD_MAGIC, final_res: 1'b1};
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_EXT;
            end
          end
        end
        PH_EXT: begin
          have             = 1'b1;
          result.out_byte  = hbyte;
          result.out_kind  = KIND_EXT;
          field_index_next = fi_inc;
          if (fi_inc >= 4'(EXT_CHARS)) begin
            field_index_next = 4'd0;
            phase_next       = PH_LEN;
          end
        end
        PH_LEN: begin
          len_wr           = 1'b1;
          field_index_next = fi_inc;
          if (fi_inc >= 4'(LENGTH_BYTES)) begin
            field_index_next = 4'd0;
            remaining_next   = len_full;
            if (len_full[63] || len_full == 64'd0) begin
              have       = 1'b1;
              result     = '{out_byte: 8'd0, out_kind: KIND_STATUS,
                             status: ST_COMPLETE, final_res: 1'b1};
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          have            = 1'b1;
          result.out_byte = hbyte;
          result.out_kind = KIND_DATA;
          remaining_next  = remaining - 64'd1;
          if (remaining == 64'd1) begin
            result.status    = ST_COMPLETE;
            result.final_res = 1'b1;
            phase_next       = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end

    // A file that ends before the decode finished reports an early end,
    // keeping any character that this same byte completed.
    if (item.last_of_file && phase_next != PH_IDLE) begin
      have             = 1'b1;
      result.status    = ST_EARLY_END;
      result.final_res = 1'b1;
      phase_next       = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 16'd0;
      bit_count    <= 3'd0;
      field_index  <= 4'd0;
    end else if (fire) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      bit_count    <= bit_count_next;
      field_index  <= field_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      shift_bits <= shift_bits_next;
      remaining  <= remaining_next;
      if (magic_wr) begin
        first_magic_seen <= hbyte;
      end
      if (len_wr) begin
        len_bytes[fi[LEN_IDX_W-1:0]] <= hbyte;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lsb_stego_stream_decoder.sv */
// Top level of the LSB steganography stream decoder: configuration registers,
// input register, decode core and result register.
// Depends on lsd_pkg, lsd_image_if, lsd_hidden_if and lsd_decode_core.
//
// Usage:
//   Image bytes enter on the image channel, one per request, with
//   first_of_file marking the start of a file and last_of_file its end.
//   Decoded extension characters, data bytes and status results leave on the
//   hidden channel; an image byte yields zero or one result.
//   Throughput is one image byte per cycle while the result register is empty
//   or being taken: the input register feeds the decode logic, which writes
//   the result register in the same cycle. A byte is accepted into the input
//   register and its result is then loaded into the result register, where it
//   shows valid.
//   When the receiver stalls, the result register holds its request and the
//   input register holds one more byte; image.ready then drops until the
//   result is taken. A byte leaves the input register only while the result
//   register is empty or being taken, whether or not it gives a result.
//   The cfg port writes header_skip (index 0), magic_first (1) and
//   magic_second (2); write only while the block is idle.
//   Reset clears both registers' valid flags, restores the register defaults
//   (54, '#', '*') and puts the decoder at the start of a file.
`default_nettype none

module lsb_stego_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  lsd_image_if.sink        image,
  lsd_hidden_if.source     hidden,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import lsd_pkg::*;

  lsd_cfg_t    cfg;
  lsd_item_t   stage_item;
  logic        stage_valid;
  lsd_result_t out_res;
  logic        out_valid;
  logic        advance;
  logic        core_have;
  lsd_result_t core_res;

  assign advance     = stage_valid && (!out_valid || hidden.ready);
  assign image.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{header_skip: HEADER_SKIP_RESET, magic_first: MAGIC_FIRST_RESET,
               magic_second: MAGIC_SECOND_RESET};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_SKIP:  cfg.header_skip  <= cfg_data;
        REG_MAGIC_FIRST:  cfg.magic_first  <= cfg_data[7:0];
        REG_MAGIC_SECOND: cfg.magic_second <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (image.valid && image.ready) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance && core_have) begin
        out_valid <= 1'b1;
      end else if (hidden.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (image.valid && image.ready) begin
      stage_item <= '{image_byte: image.image_byte, first_of_file: image.first_of_file,
                      last_of_file: image.last_of_file};
    end
    if (advance && core_have) begin
      out_res <= core_res;
    end
  end

  lsd_decode_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (stage_item),
    .cfg    (cfg),
    .have   (core_have),
    .result (core_res)
  );

  assign hidden.valid     = out_valid;
  assign hidden.out_byte  = out_res.out_byte;
  assign hidden.out_kind  = out_res.out_kind;
  assign hidden.status    = out_res.status;
  assign hidden.final_res = out_res.final_res;

endmodule

`default_nettype wire

/* hw/rtl/lsd_checker.sv */
// Port-level checks for the LSB steganography stream decoder, bound to the
// top level. Depends on lsd_pkg for the kind and status codes.
`default_nettype none

module lsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       hidden_valid,
  input wire logic       hidden_ready,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] out_kind,
  input wire logic [1:0] status,
  input wire logic       final_res
);
  import lsd_pkg::*;

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hidden_valid && !hidden_ready |=> hidden_valid && $stable(out_byte)
      && $stable(out_kind) && $stable(status) && $stable(final_res))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !hidden_valid)
    else $error("result valid right after reset");

  // Every nonzero status ends the file's decode, and only those do.
  a_final_status: assert property (@(posedge clk) disable iff (rst)
    hidden_valid |-> (final_res == (status != ST_OK)))
    else $error("final flag and status disagree");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    hidden_valid && out_kind == KIND_STATUS |-> out_byte == 8'd0 && final_res)
    else $error("status result carries a byte or is not final");

  a_ext_status: assert property (@(posedge clk) disable iff (rst)
    hidden_valid && out_kind == KIND_EXT |-> status == ST_OK || status == ST_EARLY_END)
    else $error("extension character with impossible status");

endmodule

bind lsb_stego_stream_decoder lsd_checker u_lsd_checker (
  .clk          (clk),
  .rst          (rst),
  .hidden_valid (hidden.valid),
  .hidden_ready (hidden.ready),
  .out_byte     (hidden.out_byte),
  .out_kind     (hidden.out_kind),
  .status       (hidden.status),
  .final_res    (hidden.final_res)
);

`default_nettype wire

/* bench/tb_lsb_stego_stream_decoder.sv */
// Self-checking bench for lsb_stego_stream_decoder: image files built around hidden records
// are streamed in, and every hidden byte and status is compared with a predicted copy.
// Depends on lsd_pkg, lsd_image_if, lsd_hidden_if and the decoder RTL.
`timescale 1ns / 100ps

import lsd_pkg::*;

typedef enum logic [2:0] {
  SKIP_HDR, READ_MAGIC, READ_EXT, READ_LEN, READ_DATA, DONE_IDLE
} decode_phase_t;

class stego_decode_scoreboard;
  lsd_cfg_t      cfg;
  decode_phase_t phase;
  logic [15:0]   hdr_count;
  logic [2:0]    bit_cnt;
  logic [7:0]    shift_bits;
  logic [3:0]    field_idx;
  logic [7:0]    magic_seen;
  logic [63:0]   hidden_len;
  logic [63:0]   data_count;
  lsd_result_t   expected_q[$];
  int unsigned   errors;

  function new();
    cfg.header_skip  = HEADER_SKIP_RESET;
    cfg.magic_first  = MAGIC_FIRST_RESET;
    cfg.magic_second = MAGIC_SECOND_RESET;
    errors = 0;
    start_file();
  endfunction

  function void start_file();
    phase      = SKIP_HDR;
    hdr_count  = '0;
    bit_cnt    = '0;
    shift_bits = '0;
    field_idx  = '0;
    magic_seen = '0;
    hidden_len = '0;
    data_count = '0;
  endfunction

  function void write_cfg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      REG_HEADER_SKIP:  cfg.header_skip = data;
      REG_MAGIC_FIRST:  cfg.magic_first = data[7:0];
      REG_MAGIC_SECOND: cfg.magic_second = data[7:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Advance the decode state by one accepted image byte and queue any result it gives.
  function void note_image(lsd_item_t it);
    logic [7:0]  hid;
    logic [63:0] len_mask;
    bit          have;
    lsd_result_t res;
    have = 1'b0;
    res = '{out_byte: 8'h00, out_kind: KIND_STATUS, status: ST_OK, final_res: 1'b0};
    if (it.first_of_file) start_file();
    if (phase == DONE_IDLE) return;
    if (phase == SKIP_HDR && hdr_count < cfg.header_skip) begin
      hdr_count++;
    end else begin
      if (phase == SKIP_HDR) phase = READ_MAGIC;
      shift_bits = {shift_bits[6:0], it.image_byte[0]};
      bit_cnt++;
      if (bit_cnt == 3'd0) begin
        hid = shift_bits;
        shift_bits = '0;
        case (phase)
          READ_MAGIC: begin
            if (field_idx == 4'd0) begin
              magic_seen = hid;
              field_idx = 4'd1;
            end else begin
              field_idx = 4'd0;
              if (magic_seen != cfg.magic_first || hid != cfg.magic_second) begin
                have = 1'b1;
                res.status = ST_BAD_MAGIC;
                res.final_res = 1'b1;
                phase = DONE_IDLE;
              end else begin
                phase = READ_EXT;
              end
            end
          end
          READ_EXT: begin
            have = 1'b1;
            res.out_byte = hid;
            res.out_kind = KIND_EXT;
            field_idx++;
            if (field_idx >= EXT_CHARS) begin
              field_idx = 4'd0;
              hidden_len = '0;
              phase = READ_LEN;
            end
          end
          READ_LEN: begin
            hidden_len |= 64'(hid) << (8 * field_idx[2:0]);
            field_idx++;
            if (field_idx >= LENGTH_BYTES) begin
              field_idx = 4'd0;
              // A short length field is sign-extended to 64 bits.
              if (LENGTH_BYTES < 8) begin
                len_mask = (64'd1 << (8 * LENGTH_BYTES)) - 64'd1;
                hidden_len &= len_mask;
                if (hidden_len[8 * LENGTH_BYTES - 1]) hidden_len |= ~len_mask;
              end
              data_count = '0;
              if (hidden_len == 64'd0 || hidden_len[63]) begin
                have = 1'b1;
                res.status = ST_COMPLETE;
                res.final_res = 1'b1;
                phase = DONE_IDLE;
              end else begin
                phase = READ_DATA;
              end
            end
          end
          READ_DATA: begin
            have = 1'b1;
            res.out_byte = hid;
            res.out_kind = KIND_DATA;
            data_count++;
            if (data_count >= hidden_len) begin
              res.status = ST_COMPLETE;
              res.final_res = 1'b1;
              phase = DONE_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
    // An early end outranks nothing: bad magic and completion already moved to idle.
    if (it.last_of_file && phase != DONE_IDLE) begin
      have = 1'b1;
      res.status = ST_EARLY_END;
      res.final_res = 1'b1;
      phase = DONE_IDLE;
    end
    if (have) expected_q.push_back(res);
  endfunction

  task report(string what);
    errors++;
    if (errors <= 100) $display("ERROR at %0t: %s", $time, what);
  endtask

  task check_result(lsd_result_t got);
    lsd_result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result byte %h kind %0d status %0d final %0d",
                       got.out_byte, got.out_kind, got.status, got.final_res));
      return;
    end
    want = expected_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
    if (got.out_kind !== want.out_kind)
      report($sformatf("out_kind %0d, expected %0d", got.out_kind, want.out_kind));
    if (got.status !== want.status)
      report($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.final_res !== want.final_res)
      report($sformatf("final_res %0d, expected %0d", got.final_res, want.final_res));
  endtask
endclass

module tb_lsb_stego_stream_decoder;
  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        pressure_req;

  lsd_image_if  image_ch ();
  lsd_hidden_if hidden_ch ();

  stego_decode_scoreboard sb = new();

  logic [7:0]  hidden_q[$];
  lsd_item_t   file_q[$];
  int unsigned burst_left;
  int unsigned n_driven;

  // Receiver pattern state, owned by the receiver process.
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  bit          held_once;

  lsb_stego_stream_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .image     (image_ch),
    .hidden    (hidden_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb_lsb_stego_stream_decoder failed");
    $finish;
  end

  // Receiver: checks every taken result, then picks ready for the next cycle.
  always @(posedge clk) begin : receiver
    lsd_result_t got;
    if (rst) begin
      hidden_ch.ready <= 1'b0;
    end else begin
      if (hidden_ch.valid && hidden_ch.ready) begin
        got = '{out_byte: hidden_ch.out_byte, out_kind: hidden_ch.out_kind,
                status: hidden_ch.status, final_res: hidden_ch.final_res};
        sb.check_result(got);
      end
      if (pressure_req && !held_once) begin
        held_once = 1'b1;
        hold_left = 1000;
      end
      if (hold_left != 0) begin
        hold_left--;
        hidden_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (stall_mode)
          0: hidden_ch.ready <= 1'b1;
          1: hidden_ch.ready <= 1'($urandom);
          default: hidden_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One image request; the sender runs in bursts separated by short gaps.
  task automatic drive_image(lsd_item_t it);
    if (burst_left == 0) begin
      image_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    image_ch.valid         <= 1'b1;
    image_ch.image_byte    <= it.image_byte;
    image_ch.first_of_file <= it.first_of_file;
    image_ch.last_of_file  <= it.last_of_file;
    do @(posedge clk); while (!image_ch.ready);
    sb.note_image(it);
    n_driven++;
  endtask

  task automatic drain();
    image_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // A byte with no result may still sit in the two-stage pipe.
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(logic [15:0] skip, logic [7:0] m1, logic [7:0] m2);
    logic [15:0] word;
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEADER_SKIP;
    cfg_data  <= skip;
    sb.write_cfg(REG_HEADER_SKIP, skip);
    @(posedge clk);
    // The unused upper bits of the byte registers carry junk on purpose.
    word = {8'($urandom), m1};
    cfg_index <= REG_MAGIC_FIRST;
    cfg_data  <= word;
    sb.write_cfg(REG_MAGIC_FIRST, word);
    @(posedge clk);
    word = {8'($urandom), m2};
    cfg_index <= REG_MAGIC_SECOND;
    cfg_data  <= word;
    sb.write_cfg(REG_MAGIC_SECOND, word);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hidden record: magic pair, extension, little-endian length, data.
  task automatic compose_hidden(logic [7:0] m1, logic [7:0] m2, logic [63:0] len,
                                int n_data);
    hidden_q.delete();
    hidden_q.push_back(m1);
    hidden_q.push_back(m2);
    repeat (EXT_CHARS) hidden_q.push_back(8'($urandom));
    for (int i = 0; i < LENGTH_BYTES; i++) hidden_q.push_back(len[8 * i +: 8]);
    repeat (n_data) hidden_q.push_back(8'($urandom));
  endtask

  // Spreads hidden_q over image LSBs, MSB first, after hdr random header bytes.
  task automatic compose_file(bit mark, int hdr, int cut, bit with_last, int tail);
    lsd_item_t it;
    file_q.delete();
    it.first_of_file = 1'b0;
    it.last_of_file  = 1'b0;
    repeat (hdr) begin
      it.image_byte = 8'($urandom);
      file_q.push_back(it);
    end
    foreach (hidden_q[j]) begin
      for (int k = 7; k >= 0; k--) begin
        it.image_byte = {7'($urandom), hidden_q[j][k]};
        file_q.push_back(it);
      end
    end
    while (cut > 0 && file_q.size() > cut) void'(file_q.pop_back());
    if (mark) file_q[0].first_of_file = 1'b1;
    if (with_last) file_q[file_q.size() - 1].last_of_file = 1'b1;
    repeat (tail) begin
      it.image_byte   = 8'($urandom);
      it.last_of_file = 1'($urandom);
      file_q.push_back(it);
    end
  endtask

  task automatic send_range(int lo, int hi);
    for (int i = lo; i < hi; i++) drive_image(file_q[i]);
  endtask

  task automatic send_file(bit mark, int hdr, int cut, bit with_last, int tail);
    compose_file(mark, hdr, cut, with_last, tail);
    send_range(0, file_q.size());
  endtask

  task automatic random_file();
    int unsigned pick;
    int unsigned n_data;
    int          span;
    logic [63:0] len;
    logic [7:0]  m1;
    logic [7:0]  m2;
    pick   = $urandom_range(0, 99);
    len    = 64'($urandom_range(1, 6));
    n_data = 32'(len);
    m1     = sb.cfg.magic_first;
    m2     = sb.cfg.magic_second;
    if (pick < 70) begin
      case ($urandom_range(0, 9))
        0: begin
          len = '0;
          n_data = 0;
        end
        1: begin
          len = {1'b1, 63'({$urandom, $urandom})};
          n_data = $urandom_range(0, 2);
        end
        2: begin
          // Length far beyond what arrives: the file ends inside the data.
          len = {1'b0, 63'({$urandom, $urandom})} | 64'h100;
          n_data = $urandom_range(0, 4);
        end
        default: ;
      endcase
      compose_hidden(m1, m2, len, n_data);
    end else if (pick < 85) begin
      if ($urandom_range(0, 1)) m1 ^= 8'($urandom_range(1, 255));
      else m2 ^= 8'($urandom_range(1, 255));
      compose_hidden(m1, m2, len, n_data);
    end else begin
      hidden_q.delete();
      repeat ($urandom_range(1, 12)) hidden_q.push_back(8'($urandom));
    end
    span = sb.cfg.header_skip + 8 * hidden_q.size();
    send_file($urandom_range(0, 9) != 0, sb.cfg.header_skip,
              ($urandom_range(0, 9) == 0) ? $urandom_range(1, span) : 0,
              $urandom_range(0, 9) != 0, $urandom_range(0, 3));
  endtask

  initial begin
    int unsigned phase_no;
    logic [15:0] skip;
    image_ch.valid         = 1'b0;
    image_ch.image_byte    = '0;
    image_ch.first_of_file = 1'b0;
    image_ch.last_of_file  = 1'b0;
    hidden_ch.ready        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_HEADER_SKIP;
    cfg_data     = '0;
    pressure_req = 1'b0;
    burst_left   = 0;
    n_driven     = 0;
    stall_mode   = 0;
    mode_left    = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    rst          = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Right after reset the decoder is at the start of a file without any mark.
    compose_hidden("#", "*", 64'd2, 2);
    hidden_q[2] = 8'h00;
    hidden_q[3] = 8'hff;
    send_file(1'b0, 54, 0, 1'b1, 3);
    drain();

    load_config(16'd0, 8'h00, 8'hff);
    compose_hidden(8'h01, 8'hff, 64'd1, 1);   // first magic byte wrong
    send_file(1'b1, 0, 0, 1'b1, 2);
    compose_hidden(8'h00, 8'hfe, 64'd1, 1);   // second magic byte wrong
    send_file(1'b1, 0, 0, 1'b1, 0);
    compose_hidden(8'h00, 8'hff, 64'd0, 0);   // empty length
    send_file(1'b1, 0, 0, 1'b1, 2);
    compose_hidden(8'h00, 8'hff, 64'h8000_0000_0000_0000, 0);
    send_file(1'b1, 0, 0, 1'b1, 0);
    compose_hidden(8'h00, 8'hff, '1, 1);      // minus one, trailing byte ignored
    send_file(1'b1, 0, 0, 1'b1, 0);
    compose_hidden(8'h00, 8'hff, 64'd1, 1);
    send_file(1'b1, 0, 5, 1'b1, 0);           // file ends inside the magic
    send_file(1'b1, 0, 24, 1'b1, 0);          // ends as an extension byte completes
    send_file(1'b1, 0, 16 + 8 * EXT_CHARS + 20, 1'b1, 0);
    send_file(1'b1, 0, 1, 1'b1, 0);           // one-byte file
    compose_hidden(8'h00, 8'hff, 64'd5, 2);   // ends as a data byte completes
    send_file(1'b1, 0, 0, 1'b1, 0);
    compose_hidden(8'h00, 8'hff, 64'h7fff_ffff_ffff_ffff, 1);
    send_file(1'b1, 0, 0, 1'b1, 0);
    // A file broken off without its last byte, then a fresh one restarts decoding.
    compose_hidden(8'h00, 8'hff, 64'd3, 3);
    send_file(1'b1, 0, 16 + 16 + 4, 1'b0, 0);
    compose_hidden(8'h00, 8'hff, 64'd1, 1);
    send_file(1'b1, 0, 0, 1'b1, 0);
    drain();

    // With the widest header skip the whole file stays inside the header.
    load_config(16'hffff, 8'h23, 8'h2a);
    compose_hidden(8'h23, 8'h2a, 64'd1, 1);
    send_file(1'b1, 64, 0, 1'b1, 0);
    drain();

    load_config(16'd20, 8'h23, 8'h2a);
    send_file(1'b1, 20, 3, 1'b1, 0);          // ends inside the header
    // Header skip lowered below the count reached: hidden bits start at once.
    compose_hidden(8'h23, 8'h2a, 64'd2, 2);
    compose_file(1'b1, 12, 0, 1'b1, 0);
    send_range(0, 12);
    drain();
    load_config(16'd5, 8'h23, 8'h2a);
    send_range(12, file_q.size());

    phase_no = 0;
    while (phase_no == 0 || n_driven < 1750) begin
      drain();
      case ($urandom_range(0, 7))
        0: skip = 16'd0;
        1: skip = 16'd54;
        2: skip = 16'd255;
        default: skip = 16'($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 1)) load_config(skip, 8'h23, 8'h2a);
      else load_config(skip, 8'($urandom), 8'($urandom));
      if (phase_no == 0) pressure_req <= 1'b1;
      repeat ($urandom_range(2, 5)) begin
        random_file();
      end
      phase_no++;
    end
    drain();

    if (sb.errors == 0) begin
      $display("tb_lsb_stego_stream_decoder passed");
    end else begin
      $display("tb_lsb_stego_stream_decoder failed");
    end
    $finish;
  end
endmodule
